// ----- src/cbpf_pkg.sv -----
// Shared types, constants and arithmetic helpers for the crop-box point filter.
`default_nettype none
package cbpf_pkg;

    localparam int CoordW   = 32;
    localparam int AttrW    = 64;
    localparam int CoefIdxW = 5;
    localparam int CoefCnt  = 12;
    localparam int CoefSelW = $clog2(CoefCnt);
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 32;
    localparam int QueueDepthDef = 4;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_MIN_X  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_MAX_X  = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_MIN_Y  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_MAX_Y  = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_MIN_Z  = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_MAX_Z  = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_INVERT = 3'd6;
    localparam logic [CfgIdxW-1:0] CFG_XFORM  = 3'd7;

    localparam logic CMD_POINT = 1'b0;
    localparam logic CMD_LOAD  = 1'b1;

    localparam logic signed [CoordW-1:0] Q_ONE = 32'sh0001_0000;

    typedef logic signed [CoordW-1:0] coord_t;
    typedef coord_t coef_mat_t [CoefCnt];

    // Input word
    typedef struct packed {
        logic                  cmd;
        coord_t                x_coord;
        coord_t                y_coord;
        coord_t                z_coord;
        logic                  not_finite;
        logic [AttrW-1:0]      attributes;
        logic [CoefIdxW-1:0]   coef_index;
        coord_t                coef_value;
    } in_word_t;

    // Output word
    typedef struct packed {
        coord_t           x_out;
        coord_t           y_out;
        coord_t           z_out;
        logic [AttrW-1:0] attributes_out;
    } out_word_t;

    // Kept point, or post-store load (ld set, value in x), handed front to back
    typedef struct packed {
        logic                ld;
        logic [CoefSelW-1:0] cidx;
        coord_t              x;
        coord_t              y;
        coord_t              z;
        logic [AttrW-1:0]    attr;
    } pt_t;

    // Reset value of one coefficient: identity diagonal
    function automatic coord_t ident_coef(input int i);
        return (i == 0 || i == 5 || i == 10) ? Q_ONE : '0;
    endfunction

    // Saturate a 35-bit sum to 32 bits
    function automatic coord_t sat32(input logic signed [34:0] v);
        coord_t r;
        if (v > 35'sh0_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -35'sh0_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- src/cbpf_stream_if.sv -----
// Valid/ready stream interface carrying one word per handshake.
`default_nettype none
interface cbpf_stream_if #(parameter type word_t = logic);
    logic  valid;
    logic  ready;
    word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/cbpf_xform.sv -----
// Two-stage pipelined 3x4 affine transform with floor shift and saturation.
`default_nettype none
module cbpf_xform
    import cbpf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      en,
    input  wire coef_mat_t m,
    input  wire coord_t    px,
    input  wire coord_t    py,
    input  wire coord_t    pz,
    output coord_t         qx,
    output coord_t         qy,
    output coord_t         qz
);
    // Products, shifted: 48-bit after >>16
    logic signed [47:0] prod_reg [9];
    coord_t             tr_reg   [3];
    logic signed [47:0] prod_next [9];
    coord_t             p [3];

    assign p[0] = px;
    assign p[1] = py;
    assign p[2] = pz;

    // Stage 1: nine multipliers, arithmetic shift right by 16
    always_comb
    begin
        logic signed [63:0] full;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                full = m[r*4+c] * p[c];
                prod_next[r*3+c] = full[63:16];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 9; i++)
                prod_reg[i] <= prod_next[i];
            for (int r = 0; r < 3; r++)
                tr_reg[r] <= m[r*4+3];
        end
    end

    // Stage 2: sum and saturate (combinational, registered by caller)
    always_comb
    begin
        logic signed [49:0] acc [3];
        for (int r = 0; r < 3; r++)
        begin
            acc[r] = 50'(prod_reg[r*3]) + 50'(prod_reg[r*3+1])
                   + 50'(prod_reg[r*3+2]) + 50'(tr_reg[r]);
        end
        qx = (acc[0] > 50'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
             (acc[0] < -50'sh8000_0000) ? 32'sh8000_0000 : acc[0][31:0];
        qy = (acc[1] > 50'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
             (acc[1] < -50'sh8000_0000) ? 32'sh8000_0000 : acc[1][31:0];
        qz = (acc[2] > 50'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
             (acc[2] < -50'sh8000_0000) ? 32'sh8000_0000 : acc[2][31:0];
    end
endmodule
`default_nettype wire

// ----- src/cbpf_front.sv -----
// Front end: coefficient loads, pre-transform, box test; pushes kept points and post-transform loads.
`default_nettype none
module cbpf_front
    import cbpf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    cbpf_stream_if.sink    in_s,
    input  wire coord_t    box_min_x,
    input  wire coord_t    box_max_x,
    input  wire coord_t    box_min_y,
    input  wire coord_t    box_max_y,
    input  wire coord_t    box_min_z,
    input  wire coord_t    box_max_z,
    input  wire logic      invert_select,
    input  wire logic      pre_en,
    input  wire logic      q_ready,
    output logic           q_push,
    output pt_t            q_data
);
    coef_mat_t pre_coef_reg;

    // Three-stage pipe: s1 decode, s2 products, s3 sum/test
    logic v1_reg, v2_reg, v3_reg;
    pt_t  p1_reg, p2_reg, p3_reg;
    pt_t  in_pt, kept_pt;
    logic adv;
    logic acc;
    logic is_pt, is_post_ld;
    coord_t tx, ty, tz;
    coord_t fx, fy, fz;
    logic in_box, keep;

    assign adv = !v3_reg || q_ready;
    assign in_s.ready = adv;
    assign acc = in_s.valid && adv;

    // Finite points and post-store loads travel down the pipe in order
    assign is_pt = (in_s.data.cmd == CMD_POINT) && !in_s.data.not_finite;
    assign is_post_ld = (in_s.data.cmd == CMD_LOAD) &&
                        (in_s.data.coef_index >= 5'(CoefCnt)) &&
                        (in_s.data.coef_index < 5'(2*CoefCnt));

    // Pre-transform coefficient store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CoefCnt; i++)
                pre_coef_reg[i] <= ident_coef(i);
        end
        else if (acc && in_s.data.cmd == CMD_LOAD && in_s.data.coef_index < 5'(CoefCnt))
        begin
            pre_coef_reg[CoefSelW'(in_s.data.coef_index)] <= in_s.data.coef_value;
        end
    end

    cbpf_xform u_pre (
        .clk (clk), .en (adv), .m (pre_coef_reg),
        .px (p1_reg.x), .py (p1_reg.y), .pz (p1_reg.z),
        .qx (tx), .qy (ty), .qz (tz)
    );

    // Pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= acc && (is_pt || is_post_ld);
            v2_reg <= v1_reg;
            v3_reg <= v2_reg && (p2_reg.ld || keep);
        end
    end

    // Stage 1 word: a load carries its value in x
    always_comb
    begin
        in_pt.ld   = is_post_ld;
        in_pt.cidx = CoefSelW'(in_s.data.coef_index - 5'(CoefCnt));
        in_pt.x    = is_post_ld ? in_s.data.coef_value : in_s.data.x_coord;
        in_pt.y    = in_s.data.y_coord;
        in_pt.z    = in_s.data.z_coord;
        in_pt.attr = in_s.data.attributes;
    end

    // Box test on the (optionally transformed) point
    always_comb
    begin
        fx = pre_en ? tx : p2_reg.x;
        fy = pre_en ? ty : p2_reg.y;
        fz = pre_en ? tz : p2_reg.z;
        in_box = fz > box_min_z && fz < box_max_z && fy > box_min_y &&
                 fy < box_max_y && fx > box_min_x && fx < box_max_x;
        keep = invert_select ? !in_box : in_box;
        kept_pt = p2_reg;
        if (!p2_reg.ld)
        begin
            kept_pt.x = fx;
            kept_pt.y = fy;
            kept_pt.z = fz;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg <= in_pt;
            p2_reg <= p1_reg;
            p3_reg <= kept_pt;
        end
    end

    assign q_push = v3_reg && q_ready;
    assign q_data = p3_reg;

`ifndef SYNTHESIS
    a_no_push_stall: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> q_ready)
        else $error("push without room");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !q_ready) |=> v3_reg && $stable(p3_reg))
        else $error("stalled point lost");
    a_drop_nf: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && in_s.data.cmd == CMD_POINT && in_s.data.not_finite) |=> !v1_reg)
        else $error("non-finite point entered pipe");
`endif
endmodule
`default_nettype wire

// ----- src/cbpf_back.sv -----
// Back end: point queue, post-transform pipeline and output register.
`default_nettype none
module cbpf_back
    import cbpf_pkg::*;
#(
    parameter int QueueDepth = QueueDepthDef
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      q_push,
    input  wire pt_t       q_data,
    output logic           q_ready,
    input  wire logic      post_en,
    cbpf_stream_if.source  out_s
);
    localparam int PtrW = $clog2(QueueDepth);

    pt_t              mem_reg [QueueDepth];
    logic [PtrW-1:0]  wr_reg, rd_reg;
    logic [PtrW:0]    cnt_reg;
    logic             pop;
    logic             vb1_reg, vb2_reg, vb3_reg;
    pt_t              b1_reg, b2_reg, b3_reg;
    pt_t              res_pt;
    logic             adv;
    coord_t           tx, ty, tz;
    coef_mat_t        post_coef_reg;

    // Accept a push whenever the queue has a free slot
    assign q_ready = (cnt_reg < (PtrW+1)'(QueueDepth));
    assign adv = !vb3_reg || out_s.ready;
    assign pop = adv && cnt_reg != '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (q_push)
                wr_reg <= (wr_reg == PtrW'(QueueDepth-1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == PtrW'(QueueDepth-1)) ? '0 : rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (PtrW+1)'(q_push) - (PtrW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
            mem_reg[wr_reg] <= q_data;
    end

    // Post-transform store: a load takes effect as it leaves stage 1,
    // after every point queued ahead of it has captured its products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CoefCnt; i++)
                post_coef_reg[i] <= ident_coef(i);
        end
        else if (adv && vb1_reg && b1_reg.ld)
        begin
            post_coef_reg[b1_reg.cidx] <= b1_reg.x;
        end
    end

    cbpf_xform u_post (
        .clk (clk), .en (adv), .m (post_coef_reg),
        .px (b1_reg.x), .py (b1_reg.y), .pz (b1_reg.z),
        .qx (tx), .qy (ty), .qz (tz)
    );

    // Pipeline valids; loads end at stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb1_reg <= 1'b0;
            vb2_reg <= 1'b0;
            vb3_reg <= 1'b0;
        end
        else if (adv)
        begin
            vb1_reg <= pop;
            vb2_reg <= vb1_reg && !b1_reg.ld;
            vb3_reg <= vb2_reg;
        end
    end

    // Stage 3 result: sums line up with the point in stage 2
    always_comb
    begin
        res_pt = b2_reg;
        if (post_en)
        begin
            res_pt.x = tx;
            res_pt.y = ty;
            res_pt.z = tz;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_reg <= mem_reg[rd_reg];
            b2_reg <= b1_reg;
            b3_reg <= res_pt;
        end
    end

    assign out_s.valid = vb3_reg;
    assign out_s.data  = '{x_out: b3_reg.x, y_out: b3_reg.y, z_out: b3_reg.z,
                           attributes_out: b3_reg.attr};

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> cnt_reg < (PtrW+1)'(QueueDepth))
        else $error("queue overflow");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (PtrW+1)'(QueueDepth))
        else $error("queue count out of range");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_s.valid && !out_s.ready) |=> out_s.valid)
        else $error("output dropped");
`endif
endmodule
`default_nettype wire

// ----- src/crop_box_point_filter.sv -----
// Top level of the crop-box point filter: config registers, front and back.
// Usage:
//   in_s  carries one word per point (cmd=0) or coefficient load (cmd=1).
//   out_s carries one word per kept point; rejected, non-finite and load
//   words produce nothing. Post-transform loads travel through the queue
//   so they apply in order with the points around them.
//   Configuration: write cfg_we with cfg_index 0..7 while the block is idle.
// Throughput: one word per cycle in and out while out_s.ready stays high;
//   both transforms are pipelined (products, then sum and saturate).
// Path: an accepted word passes 3 front stages, 1 queue slot and 3 post
//   stages on its way to the output register.
// Reset: box opens to full range, invert and transforms off, both
//   coefficient stores load identity; no clearing pass.
// Receiver stall: the output register holds; the point queue absorbs the
//   front pipeline, and in_s.ready drops once the front's last stage is
//   blocked by a full queue.
`default_nettype none
module crop_box_point_filter
    import cbpf_pkg::*;
#(
    parameter int QueueDepth = QueueDepthDef
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    cbpf_stream_if.sink               in_s,
    cbpf_stream_if.source             out_s,
    input  wire logic                 cfg_we,
    input  wire logic [CfgIdxW-1:0]   cfg_index,
    input  wire logic [CfgDataW-1:0]  cfg_data
);
    coord_t     min_x_reg, max_x_reg, min_y_reg, max_y_reg, min_z_reg, max_z_reg;
    logic       invert_reg;
    logic [1:0] xform_reg;
    logic       q_push, q_ready;
    pt_t        q_data;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg  <= 32'sh8000_0000;
            max_x_reg  <= 32'sh7FFF_FFFF;
            min_y_reg  <= 32'sh8000_0000;
            max_y_reg  <= 32'sh7FFF_FFFF;
            min_z_reg  <= 32'sh8000_0000;
            max_z_reg  <= 32'sh7FFF_FFFF;
            invert_reg <= 1'b0;
            xform_reg  <= 2'b00;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_X:  min_x_reg  <= cfg_data;
                CFG_MAX_X:  max_x_reg  <= cfg_data;
                CFG_MIN_Y:  min_y_reg  <= cfg_data;
                CFG_MAX_Y:  max_y_reg  <= cfg_data;
                CFG_MIN_Z:  min_z_reg  <= cfg_data;
                CFG_MAX_Z:  max_z_reg  <= cfg_data;
                CFG_INVERT: invert_reg <= cfg_data[0];
                CFG_XFORM:  xform_reg  <= cfg_data[1:0];
            endcase
        end
    end

    cbpf_front u_front (
        .clk (clk), .rst_n (rst_n), .in_s (in_s),
        .box_min_x (min_x_reg), .box_max_x (max_x_reg),
        .box_min_y (min_y_reg), .box_max_y (max_y_reg),
        .box_min_z (min_z_reg), .box_max_z (max_z_reg),
        .invert_select (invert_reg), .pre_en (xform_reg[0]),
        .q_ready (q_ready), .q_push (q_push), .q_data (q_data)
    );

    cbpf_back #(.QueueDepth (QueueDepth)) u_back (
        .clk (clk), .rst_n (rst_n), .q_push (q_push), .q_data (q_data),
        .q_ready (q_ready), .post_en (xform_reg[1]),
        .out_s (out_s)
    );
endmodule
`default_nettype wire
